// ----- src/min_runtime_run_queue_top_defines.svh -----
// assertion macros for the least-runtime run queue
// used by the controller, no other dependencies
`ifndef MIN_RUNTIME_RUN_QUEUE_TOP_DEFINES_SVH
`define MIN_RUNTIME_RUN_QUEUE_TOP_DEFINES_SVH

// implication checked in the next cycle
`define MRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked in the same cycle
`define MRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/mrq_pkg.sv -----
// shared types and codes of the least-runtime run queue
// no dependencies
package mrq_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SET    = 2'd2,
        CMD_PICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [62:0] runtime;
    } entry_t;

    // controller to cell row
    typedef struct packed {
        logic shift;
        logic push;
        logic add;
    } row_ctrl_t;

    // per-cell load control
    typedef struct packed {
        logic we;
        logic ext;
    } cell_sel_t;

endpackage

// ----- src/mrq_if.sv -----
// channel interfaces of the least-runtime run queue
// command channel and result channel, no dependencies
interface mrq_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  entity_id;
    logic [62:0] runtime;

    modport source (output valid, output command, output entity_id, output runtime,
                    input ready);
    modport sink (input valid, input command, input entity_id, input runtime,
                  output ready);
endinterface

interface mrq_res_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] chosen_id;
    logic [1:0] status;

    modport source (output valid, output found, output chosen_id, output status,
                    input ready);
    modport sink (input valid, input found, input chosen_id, input status,
                  output ready);
endinterface

// ----- src/mrq_cell.sv -----
// one queue slot: id and runtime, loaded from its right neighbor or the controller
// depends on mrq_pkg
module mrq_cell
    import mrq_pkg::*;
(
    input  logic      clk,
    input  cell_sel_t sel,
    input  entry_t    nbr,
    input  entry_t    ext,
    output entry_t    q
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = sel.ext ? ext : nbr;
    end

    always_ff @(posedge clk)
    begin
        if (sel.we)
        begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

// ----- src/mrq_ctrl.sv -----
// command sequencer: rotates the cell row through the head cell for each scan
// depends on mrq_pkg, mrq_if and min_runtime_run_queue_top_defines.svh
`include "min_runtime_run_queue_top_defines.svh"

module mrq_ctrl
    import mrq_pkg::*;
#(
    parameter int SLOTS = 16,
    localparam int CW = $clog2(SLOTS + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    mrq_cmd_if.sink       cmd,
    mrq_res_if.source     res,
    input  entry_t        head,
    output row_ctrl_t     row_ctrl,
    output entry_t        push_entry,
    output logic [CW-1:0] count,
    output logic [CW-1:0] len
);

    state_t        state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [7:0]    id_reg, id_next;
    logic [62:0]   rt_reg, rt_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic          hit_reg, hit_next;
    logic [62:0]   best_rt_reg, best_rt_next;
    logic [7:0]    best_id_reg, best_id_next;
    logic          res_valid_reg, res_valid_next;
    logic          res_found_reg, res_found_next;
    logic [7:0]    res_id_reg, res_id_next;
    status_t       res_status_reg, res_status_next;

    logic accept;
    logic match;
    logic full;

    assign accept = cmd.valid && cmd.ready;
    assign match  = (head.id == id_reg);
    assign full   = (count_reg >= CW'(SLOTS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd_t'(cmd.command) == CMD_ADD || count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (steps_reg == CW'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready       = (state_reg == S_IDLE);
        row_ctrl        = '0;
        push_entry      = head;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        rt_next         = rt_reg;
        count_next      = count_reg;
        len_next        = len_reg;
        steps_next      = steps_reg;
        hit_next        = hit_reg;
        best_rt_next    = best_rt_reg;
        best_id_next    = best_id_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_found_next  = res_found_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;

        if (accept)
        begin
            cmd_next   = cmd_t'(cmd.command);
            id_next    = cmd.entity_id;
            rt_next    = cmd.runtime;
            len_next   = count_reg;
            steps_next = count_reg;
            hit_next   = 1'b0;
            if (cmd_t'(cmd.command) == CMD_ADD)
            begin
                hit_next = full;
                if (!full)
                begin
                    row_ctrl.add       = 1'b1;
                    push_entry.id      = cmd.entity_id;
                    push_entry.runtime = cmd.runtime;
                    count_next         = count_reg + CW'(1);
                end
            end
        end

        if (state_reg == S_SCAN)
        begin
            row_ctrl.shift = 1'b1;
            row_ctrl.push  = 1'b1;
            steps_next     = steps_reg - CW'(1);
            unique case (cmd_reg)
                CMD_PICK:
                begin
                    if (!hit_reg || head.runtime < best_rt_reg)
                    begin
                        best_rt_next = head.runtime;
                        best_id_next = head.id;
                    end
                    hit_next = 1'b1;
                end
                CMD_SET:
                begin
                    if (match)
                    begin
                        push_entry.runtime = rt_reg;
                        hit_next           = 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (match && !hit_reg)
                    begin
                        // drop the entry and shrink the ring
                        row_ctrl.push = 1'b0;
                        len_next      = len_reg - CW'(1);
                        hit_next      = 1'b1;
                    end
                end
                CMD_ADD:
                begin
                    row_ctrl.push = 1'b1;
                end
                default:
                begin
                    row_ctrl.push = 1'b1;
                end
            endcase
            if (steps_reg == CW'(1) && cmd_reg == CMD_REMOVE && hit_next)
            begin
                count_next = count_reg - CW'(1);
            end
        end

        if (state_reg == S_DONE && (!res_valid_reg || res.ready))
        begin
            res_valid_next = 1'b1;
            res_found_next = 1'b0;
            res_id_next    = '0;
            unique case (cmd_reg)
                CMD_ADD:
                begin
                    res_status_next = hit_reg ? ST_FULL : ST_OK;
                end
                CMD_REMOVE, CMD_SET:
                begin
                    res_status_next = hit_reg ? ST_OK : ST_ABSENT;
                end
                CMD_PICK:
                begin
                    res_status_next = ST_OK;
                    res_found_next  = hit_reg;
                    res_id_next     = hit_reg ? best_id_reg : 8'd0;
                end
                default:
                begin
                    res_status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        rt_reg         <= rt_next;
        len_reg        <= len_next;
        steps_reg      <= steps_next;
        hit_reg        <= hit_next;
        best_rt_reg    <= best_rt_next;
        best_id_reg    <= best_id_next;
        res_found_reg  <= res_found_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
    end

    assign res.valid     = res_valid_reg;
    assign res.found     = res_found_reg;
    assign res.chosen_id = res_id_reg;
    assign res.status    = res_status_reg;
    assign count         = count_reg;
    assign len           = len_reg;

    `MRQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(SLOTS), "occupancy above slot count")
    `MRQ_ASSERT_NOW(a_scan_steps, state_reg == S_SCAN, steps_reg != '0 && len_reg != '0,
                    "scan running with no entries left")
    `MRQ_ASSERT_NEXT(a_add_grows,
                     accept && cmd_t'(cmd.command) == CMD_ADD && !full,
                     count_reg == $past(count_reg) + CW'(1), "add did not grow the queue")
    `MRQ_ASSERT_NOW(a_found_ok, res.valid && res.found, res.status == ST_OK,
                    "pick result with bad status")

endmodule

// ----- src/min_runtime_run_queue_top.sv -----
// least-runtime run queue: row of slot cells driven by a scan sequencer
// depends on mrq_pkg, mrq_if, mrq_cell and mrq_ctrl
//
// usage:
//   cmd channel takes one transaction per command: add, remove, set runtime, pick
//   res channel returns exactly one transaction per command, in order
//   entries sit in a row of cells in queue order; remove, set and pick rotate the
//   row through the head cell, one entry per cycle, so the queue is back in place
//   once every entry has passed through the head cell
// sequencing:
//   add goes from accept straight to the done state, which loads the result register
//   once it is free; remove, set and pick first pass through the scan state, which
//   rotates every entry held at accept (at most SLOTS); on an empty queue they skip it
//   one command is in work at a time, the next is accepted after its result
//   has moved into the output register
// reset:
//   occupancy goes to zero and no result is pending; slot contents are left as is
// stall:
//   the result waits in the output register while res.ready is low; one more
//   command may be accepted and worked, then cmd.ready stays low until the
//   waiting result is taken
module min_runtime_run_queue_top
    import mrq_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    mrq_cmd_if.sink   cmd,
    mrq_res_if.source res
);

    localparam int CW = $clog2(SLOTS + 1);

    entry_t        cell_q [SLOTS];
    row_ctrl_t     row_ctrl;
    entry_t        push_entry;
    logic [CW-1:0] count;
    logic [CW-1:0] len;

    mrq_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .res        (res),
        .head       (cell_q[0]),
        .row_ctrl   (row_ctrl),
        .push_entry (push_entry),
        .count      (count),
        .len        (len)
    );

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        cell_sel_t sel;
        entry_t    nbr;
        logic      add_here;
        logic      push_here;

        assign add_here  = row_ctrl.add && (count == CW'(i));
        assign push_here = row_ctrl.shift && row_ctrl.push && (len == CW'(i + 1));
        assign sel.we    = row_ctrl.shift || add_here;
        assign sel.ext   = add_here || push_here;

        if (i == SLOTS - 1)
        begin : g_last
            assign nbr = push_entry;
        end
        else
        begin : g_mid
            assign nbr = cell_q[i + 1];
        end

        mrq_cell u_cell (
            .clk (clk),
            .sel (sel),
            .nbr (nbr),
            .ext (push_entry),
            .q   (cell_q[i])
        );
    end

endmodule

// ----- test/min_runtime_run_queue_top_test.sv -----
// testbench for the least-runtime run queue (min_runtime_run_queue_top)
// predicts every result from its own copy of the queue and checks each result transaction
// depends on mrq_pkg, mrq_if and the rtl under src
`timescale 1ns / 1ps

module min_runtime_run_queue_top_test
    import mrq_pkg::*;
();

    localparam int QUEUE_SLOTS = 16;
    localparam int QW = $clog2(QUEUE_SLOTS);
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 3 * (QUEUE_SLOTS + 2);
    localparam int MAX_REPORTED = 10;
    localparam logic [62:0] RUNTIME_MAX = {63{1'b1}};

    typedef struct packed {
        logic       found;
        logic [7:0] chosen_id;
        status_t    status;
    } outcome_t;

    logic clk;
    logic rst_n;

    mrq_cmd_if cmd_bus ();
    mrq_res_if res_bus ();

    min_runtime_run_queue_top #(
        .SLOTS(QUEUE_SLOTS)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_bus.sink),
        .res  (res_bus.source)
    );

    entry_t      run_queue [QUEUE_SLOTS];
    int unsigned queued_count = 0;
    outcome_t    expected_results [$];
    outcome_t    oldest_expected;
    int unsigned mismatch_count = 0;
    int unsigned source_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned stall_requests = 0;
    int unsigned stall_length = 0;
    int unsigned cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic outcome_t apply_command(input cmd_t op, input logic [7:0] id,
                                               input logic [62:0] rt);
        outcome_t    result;
        int unsigned pos;
        int unsigned best;
        bit          hit;
        result.found = 1'b0;
        result.chosen_id = 8'd0;
        result.status = ST_OK;
        hit = 1'b0;
        case (op)
            CMD_ADD:
            begin
                if (queued_count >= QUEUE_SLOTS)
                    result.status = ST_FULL;
                else
                begin
                    run_queue[QW'(queued_count)].id = id;
                    run_queue[QW'(queued_count)].runtime = rt;
                    queued_count++;
                end
            end
            CMD_REMOVE:
            begin
                pos = 0;
                while (pos < queued_count && run_queue[QW'(pos)].id != id)
                    pos++;
                if (pos == queued_count)
                    result.status = ST_ABSENT;
                else
                begin
                    while (pos + 1 < queued_count)
                    begin
                        run_queue[QW'(pos)] = run_queue[QW'(pos + 1)];
                        pos++;
                    end
                    queued_count--;
                end
            end
            CMD_SET:
            begin
                for (pos = 0; pos < queued_count; pos++)
                begin
                    if (run_queue[QW'(pos)].id == id)
                    begin
                        run_queue[QW'(pos)].runtime = rt;
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    result.status = ST_ABSENT;
            end
            default:
            begin
                if (queued_count != 0)
                begin
                    best = 0;
                    for (pos = 1; pos < queued_count; pos++)
                        if (run_queue[QW'(pos)].runtime < run_queue[QW'(best)].runtime)
                            best = pos;
                    result.found = 1'b1;
                    result.chosen_id = run_queue[QW'(best)].id;
                end
            end
        endcase
        return result;
    endfunction

    function automatic logic [62:0] draw_runtime();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        case ($urandom_range(5))
            0: return '0;
            1: return RUNTIME_MAX;
            2, 3: return 63'($urandom_range(3));
            default: return wide[62:0];
        endcase
    endfunction

    function automatic logic [7:0] draw_entity_id();
        int unsigned roll;
        roll = $urandom_range(99);
        if (queued_count != 0 && roll < 50)
            return run_queue[QW'($urandom_range(queued_count - 1))].id;
        else if (roll < 85)
            return 8'($urandom_range(7));
        else
            return 8'($urandom_range(255));
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // one command transaction, prediction taken at acceptance
    task automatic send_command(input cmd_t op, input logic [7:0] id, input logic [62:0] rt);
        while (source_idle_pct != 0 && $urandom_range(99) < source_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.command <= op;
        cmd_bus.entity_id <= id;
        cmd_bus.runtime <= rt;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        expected_results.push_back(apply_command(op, id, rt));
    endtask

    // result sink with random and long stalls
    initial
    begin : result_sink
        int unsigned hold_left;
        int unsigned stalls_seen;
        hold_left = 0;
        stalls_seen = 0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_requests != stalls_seen)
            begin
                stalls_seen = stall_requests;
                hold_left = stall_length;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (expected_results.size() == 0)
                log_mismatch($sformatf("unexpected transaction found=%0b id=%0d status=%0d",
                                       res_bus.found, res_bus.chosen_id, res_bus.status));
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (res_bus.found !== oldest_expected.found
                    || res_bus.chosen_id !== oldest_expected.chosen_id
                    || res_bus.status !== oldest_expected.status)
                    log_mismatch($sformatf(
                        "expected found=%0b id=%0d status=%0d, got found=%0b id=%0d status=%0d",
                        oldest_expected.found, oldest_expected.chosen_id,
                        oldest_expected.status, res_bus.found, res_bus.chosen_id,
                        res_bus.status));
            end
        end
    end

    task automatic test_directed();
        int unsigned k;
        send_command(CMD_PICK, 8'd0, '0);
        send_command(CMD_REMOVE, 8'd5, '0);
        send_command(CMD_SET, 8'd5, RUNTIME_MAX);
        send_command(CMD_ADD, 8'd0, RUNTIME_MAX);
        send_command(CMD_ADD, 8'hff, '0);
        send_command(CMD_ADD, 8'd7, '0);
        // tie on zero runtime, earlier entry wins
        send_command(CMD_PICK, 8'hff, RUNTIME_MAX);
        send_command(CMD_ADD, 8'd7, 63'd5);
        send_command(CMD_SET, 8'd7, 63'h2aaa_aaaa_aaaa_aaaa);
        send_command(CMD_PICK, 8'd0, '0);
        send_command(CMD_REMOVE, 8'd7, '0);
        send_command(CMD_SET, 8'hff, 63'h5555_5555_5555_5555);
        send_command(CMD_PICK, 8'd0, '0);
        k = 0;
        while (queued_count < QUEUE_SLOTS)
        begin
            send_command(CMD_ADD, 8'h10 + 8'(k), draw_runtime());
            k++;
        end
        send_command(CMD_ADD, 8'h80, 63'd1);
        send_command(CMD_PICK, 8'd0, '0);
    endtask

    task automatic test_random(input int unsigned count, input int unsigned tx_pct,
                               input int unsigned rx_pct);
        int unsigned n;
        int unsigned roll;
        bit          fill_bias;
        cmd_t        op;
        source_idle_pct = tx_pct;
        sink_idle_pct = rx_pct;
        for (n = 0; n < count; n++)
        begin
            fill_bias = ((n / 50) % 2 == 0);
            roll = $urandom_range(99);
            if (roll < (fill_bias ? 45 : 20))
                op = CMD_ADD;
            else if (roll < (fill_bias ? 60 : 50))
                op = CMD_REMOVE;
            else if (roll < 72)
                op = CMD_SET;
            else
                op = CMD_PICK;
            send_command(op, draw_entity_id(), draw_runtime());
        end
    endtask

    // long sink hold-off so the result waits and the command input stalls
    task automatic test_backpressure();
        int unsigned n;
        source_idle_pct = 0;
        sink_idle_pct = 0;
        stall_length = 400;
        stall_requests++;
        for (n = 0; n < 30; n++)
        begin
            if (n % 3 == 2)
                send_command(CMD_PICK, draw_entity_id(), draw_runtime());
            else
                send_command(CMD_ADD, draw_entity_id(), draw_runtime());
        end
    endtask

    task automatic finish_drain();
        cmd_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = CMD_PICK;
        cmd_bus.entity_id = 8'd0;
        cmd_bus.runtime = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(350, 26, 72);
        test_random(350, 72, 26);
        test_backpressure();
        test_random(300, 0, 0);
        finish_drain();

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/mrq_pkg.sv
src/mrq_if.sv
src/mrq_cell.sv
src/mrq_ctrl.sv
src/min_runtime_run_queue_top.sv
test/min_runtime_run_queue_top_test.sv
